// ----- src/rcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm_pkg: shared constants and helpers
// Widths of the stream words and the degree count used by the ordering block.
// ----------------------------------------------------------------------------
package rcm_pkg;

   localparam int MAX_SIZE_DEF = 32;   // default storage depth
   localparam int ROW_W        = 32;   // width of one row pattern
   localparam int DEG_W        = 6;    // degree 0..32
   localparam int SIZE_W       = 6;    // matrix_size register width
   localparam int OUT_IDX_W    = 5;    // original_row / out_position
   localparam int RSP_W        = 16;   // two 5-bit fields padded to bytes

   // count of set bits: nibble counts first, then a short sum
   function automatic logic [DEG_W-1:0] pop_count(input logic [ROW_W-1:0] x);
      logic [2:0]       nib [ROW_W/4];
      logic [DEG_W-1:0] sum;
      for (int i = 0; i < ROW_W/4; i++) begin
         nib[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
      end
      sum = '0;
      for (int i = 0; i < ROW_W/4; i++) begin
         sum = sum + DEG_W'(nib[i]);
      end
      return sum;
   endfunction

endpackage

// ----- src/rcm_lanes.sv -----
// ----------------------------------------------------------------------------
// rcm_lanes: per-row candidate lanes
// Each lane forms a sort key {not candidate, degree, row index} for its row.
// ----------------------------------------------------------------------------
module rcm_lanes #(
   parameter int LANES = 32,
   parameter int IW    = 5
) (
   input  logic [LANES-1:0]                           cand,
   input  logic [LANES*rcm_pkg::DEG_W-1:0]            deg_flat,
   output logic [LANES*(1+rcm_pkg::DEG_W+IW)-1:0]     keys
);
   import rcm_pkg::*;

   localparam int KW = 1 + DEG_W + IW;

   // one key per lane; smaller key wins, lower index breaks ties
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         keys[i*KW +: KW] = {~cand[i], deg_flat[i*DEG_W +: DEG_W], IW'(i)};
      end
   end

endmodule

// ----- src/rcm_merge.sv -----
// ----------------------------------------------------------------------------
// rcm_merge: minimum-key merge
// Binary compare tree over the lane keys; yields the winning row index.
// ----------------------------------------------------------------------------
module rcm_merge #(
   parameter int LANES = 32,
   parameter int IW    = 5
) (
   input  logic [LANES*(1+rcm_pkg::DEG_W+IW)-1:0] keys,
   output logic [IW-1:0]                          best_idx
);
   import rcm_pkg::*;

   localparam int KW = 1 + DEG_W + IW;
   localparam int P  = 1 << IW;

   logic [KW-1:0] lvl [IW+1][P];

   // tree levels; padded leaves carry the largest key
   always_comb begin
      for (int l = 0; l <= IW; l++) begin
         for (int j = 0; j < P; j++) begin
            lvl[l][j] = '1;
         end
      end
      for (int j = 0; j < LANES; j++) begin
         lvl[0][j] = keys[j*KW +: KW];
      end
      for (int l = 0; l < IW; l++) begin
         for (int j = 0; j < (P >> (l + 1)); j++) begin
            lvl[l+1][j] = (lvl[l][2*j+1] < lvl[l][2*j]) ? lvl[l][2*j+1] : lvl[l][2*j];
         end
      end
      best_idx = lvl[IW][0][IW-1:0];
   end

endmodule

// ----- src/reverse_cuthill_mckee_order.sv -----
// ----------------------------------------------------------------------------
// reverse_cuthill_mckee_order: RCM ordering of a loaded sparsity pattern
// Loads one row pattern per word, builds the Cuthill-McKee order with a
// lane-parallel least-degree pick, then streams the reversed order.
// ----------------------------------------------------------------------------
//  channel  | dir | word contents
//  req_     | in  | tdata[31:0] row_pattern
//  rsp_     | out | tdata[4:0] original_row, [9:5] out_position; tlast last_of_run
//  csr_     | in  | data[5:0] matrix_size
//
//  After the last row is loaded the order is built: each dequeued row is read
//  from the single-ported queue memory, each placed row is taken from the
//  registered least-degree pick and written to the queue, and a restart picks
//  among all unplaced rows when the queue runs empty. Each result is then held
//  until rsp_ takes it. No rows are accepted while ordering, while emitting or
//  in a cycle with a csr_ write. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module reverse_cuthill_mckee_order #(
   parameter int MAX_SIZE = rcm_pkg::MAX_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rcm_pkg::ROW_W-1:0]    req_tdata,   // [31:0] row_pattern
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [rcm_pkg::RSP_W-1:0]    rsp_tdata,   // [4:0] original_row, [9:5] out_position
   output logic                         rsp_tlast,   // last_of_run
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rcm_pkg::SIZE_W-1:0]   csr_data     // [5:0] matrix_size
);
   import rcm_pkg::*;

   localparam int CAP = (MAX_SIZE < 32) ? MAX_SIZE : 32;
   localparam int IW  = $clog2(CAP);
   localparam int CW  = $clog2(CAP + 1);
   localparam int KW  = 1 + DEG_W + IW;

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_SEL  = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_PK1  = 4'd3;
   localparam logic [3:0] S_PK2  = 4'd4;
   localparam logic [3:0] S_ORD  = 4'd5;
   localparam logic [3:0] S_OLD  = 4'd6;
   localparam logic [3:0] S_OWT  = 4'd7;

   logic [3:0]       state_ff;
   logic [CW-1:0]    eff_ff, rows_ff, head_ff, tail_ff, k_ff;
   logic [CAP-1:0]   placed_ff, cand_ff;
   logic             restart_ff;
   logic [IW-1:0]    best_ff;
   logic [CAP-1:0]   pat_ff [CAP];
   logic [DEG_W-1:0] deg_ff [CAP];
   logic [IW-1:0]    qmem [CAP];
   logic [IW-1:0]    q_rd_ff;
   logic             rsp_valid_ff, rsp_last_ff;
   logic [OUT_IDX_W-1:0] rsp_row_ff, rsp_pos_ff;

   logic [CAP-1:0]   col_mask;
   logic [ROW_W-1:0] deg_mask;
   logic [CW-1:0]    eff_in;
   logic [IW-1:0]    mem_addr, best_idx;
   logic             mem_rd, mem_wr;
   logic [CAP*DEG_W-1:0] deg_flat;
   logic [CAP*KW-1:0]    keys;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_LOAD) && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_W - 2*OUT_IDX_W)'(0), rsp_pos_ff, rsp_row_ff};

   // effective size from a register write: 0 acts as 1, saturate at CAP
   always_comb begin
      if (csr_data == '0) eff_in = CW'(1);
      else if (int'(csr_data) > CAP) eff_in = CW'(CAP);
      else eff_in = CW'(csr_data);
   end

   // column masks for the active size
   always_comb begin
      for (int i = 0; i < CAP; i++) col_mask[i] = (i < int'(eff_ff));
      for (int i = 0; i < ROW_W; i++) deg_mask[i] = (i < CAP) && (i < int'(eff_ff));
   end

   // candidate lanes and merge
   always_comb begin
      for (int i = 0; i < CAP; i++) deg_flat[i*DEG_W +: DEG_W] = deg_ff[i];
   end

   rcm_lanes #(.LANES(CAP), .IW(IW)) u_lanes (
      .cand(cand_ff), .deg_flat(deg_flat), .keys(keys));

   rcm_merge #(.LANES(CAP), .IW(IW)) u_merge (
      .keys(keys), .best_idx(best_idx));

   // queue memory port control
   always_comb begin
      mem_wr = (state_ff == S_PK2);
      mem_rd = (state_ff == S_ORD) || (state_ff == S_SEL);
      priority if (state_ff == S_PK2) mem_addr = tail_ff[IW-1:0];
      else if (state_ff == S_ORD)     mem_addr = IW'(eff_ff - CW'(1) - k_ff);
      else                            mem_addr = head_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_wr) qmem[mem_addr] <= best_ff;
      if (mem_rd) q_rd_ff <= qmem[mem_addr];
   end

   // row storage during loading
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pat_ff[rows_ff[IW-1:0]] <= req_tdata[CAP-1:0];
         deg_ff[rows_ff[IW-1:0]] <= pop_count(req_tdata & deg_mask);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         eff_ff       <= CW'(CAP);
         rows_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         k_ff         <= '0;
         placed_ff    <= '0;
         cand_ff      <= '0;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            eff_ff  <= eff_in;
            rows_ff <= '0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_tvalid && !csr_valid) begin
                  if (rows_ff + CW'(1) == eff_ff) begin
                     rows_ff   <= '0;
                     placed_ff <= '0;
                     head_ff   <= '0;
                     tail_ff   <= '0;
                     state_ff  <= S_SEL;
                  end else begin
                     rows_ff <= rows_ff + CW'(1);
                  end
               end
            end
            S_SEL: begin
               if (tail_ff == eff_ff) begin
                  k_ff     <= '0;
                  state_ff <= S_ORD;
               end else if (head_ff == tail_ff) begin
                  cand_ff    <= col_mask & ~placed_ff;
                  restart_ff <= 1'b1;
                  state_ff   <= S_PK1;
               end else begin
                  head_ff    <= head_ff + CW'(1);
                  restart_ff <= 1'b0;
                  state_ff   <= S_RD;
               end
            end
            S_RD: begin
               cand_ff  <= pat_ff[q_rd_ff] & col_mask & ~placed_ff;
               state_ff <= S_PK1;
            end
            S_PK1: begin
               if (cand_ff == '0) begin
                  state_ff <= S_SEL;
               end else begin
                  best_ff  <= best_idx;
                  state_ff <= S_PK2;
               end
            end
            S_PK2: begin
               placed_ff <= placed_ff | (CAP'(1) << best_ff);
               cand_ff   <= cand_ff & ~(CAP'(1) << best_ff);
               tail_ff   <= tail_ff + CW'(1);
               state_ff  <= restart_ff ? S_SEL : S_PK1;
            end
            S_ORD: begin
               state_ff <= S_OLD;
            end
            S_OLD: begin
               rsp_valid_ff <= 1'b1;
               rsp_row_ff   <= OUT_IDX_W'(q_rd_ff);
               rsp_pos_ff   <= OUT_IDX_W'(k_ff);
               rsp_last_ff  <= (k_ff == eff_ff - CW'(1));
               state_ff     <= S_OWT;
            end
            S_OWT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (k_ff == eff_ff - CW'(1)) begin
                     state_ff <= S_LOAD;
                  end else begin
                     k_ff     <= k_ff + CW'(1);
                     state_ff <= S_ORD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   // checks
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> (tail_ff <= eff_ff))
      else $error("queue tail beyond matrix size");

   a_placed_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> ($countones(placed_ff) == int'(tail_ff)))
      else $error("placed rows disagree with queue tail");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (int'(rsp_pos_ff) == int'(eff_ff) - 1))
      else $error("last flag off the final position");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("loading while results pending");

endmodule
